### design/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg: shared types and constants of the raster to braille cell converter
// geometry of the cell store, byte codes, braille ascii table, command format
// ----------------------------------------------------------------------------
package rbc_pkg;

    // geometry
    localparam int MAX_COLUMNS = 2048;
    localparam int STORE_CELLS = (MAX_COLUMNS + 1) / 2;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int IDX_W       = $clog2(STORE_CELLS);
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int MODE_W      = 3;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

    // output byte codes
    localparam logic [7:0] UTF8_LEAD = 8'hE2;
    localparam logic [7:0] UTF8_MID  = 8'hA0;
    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] NEWLINE   = 8'h0A;

    // braille ascii character for each 6-dot cell
    localparam logic [7:0] BRF_TABLE [64] = '{
        8'h20, 8'h41, 8'h31, 8'h42, 8'h27, 8'h4B, 8'h32, 8'h4C,
        8'h40, 8'h43, 8'h49, 8'h46, 8'h2F, 8'h4D, 8'h53, 8'h50,
        8'h22, 8'h45, 8'h33, 8'h48, 8'h39, 8'h4F, 8'h36, 8'h52,
        8'h5E, 8'h44, 8'h4A, 8'h47, 8'h3E, 8'h4E, 8'h54, 8'h51,
        8'h2C, 8'h2A, 8'h35, 8'h3C, 8'h2D, 8'h55, 8'h38, 8'h56,
        8'h2E, 8'h25, 8'h5B, 8'h24, 8'h2B, 8'h58, 8'h21, 8'h26,
        8'h3B, 8'h3A, 8'h34, 8'h5C, 8'h30, 8'h5A, 8'h37, 8'h28,
        8'h5F, 8'h3F, 8'h57, 8'h5D, 8'h23, 8'h59, 8'h29, 8'h3D
    };

    // format_mode register codes
    typedef enum logic [MODE_W-1:0] {
        MODE_BRF6   = 3'd0,
        MODE_UTF8_8 = 3'd1,
        MODE_UTF8_6 = 3'd2,
        MODE_ISO8   = 3'd3,
        MODE_ISO6   = 3'd4
    } mode_t;

    // register indexes on the config port
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        FMT_BRF,
        FMT_UTF8,
        FMT_ISO
    } cell_fmt_t;

    typedef struct packed {
        logic        eight_dot;
        logic        iso;
        cell_fmt_t   fmt;
    } mode_dec_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [MODE_W-1:0]   mode;
    } cfg_t;

    // one entry of the command queue: all bytes one pixel causes
    typedef struct packed {
        logic [7:0] dots;
        cell_fmt_t  fmt;
        logic       has_cell;
        logic       has_nl;
        logic       img_done;
    } cmd_t;

    function automatic mode_dec_t decode_mode(input logic [MODE_W-1:0] mode);
        mode_dec_t dec;
        dec = '{eight_dot: 1'b0, iso: 1'b0, fmt: FMT_BRF};
        unique case (mode) inside
            MODE_UTF8_8:
            begin
                dec.eight_dot = 1'b1;
                dec.fmt       = FMT_UTF8;
            end
            MODE_UTF8_6:
            begin
                dec.fmt = FMT_UTF8;
            end
            MODE_ISO8:
            begin
                dec.eight_dot = 1'b1;
                dec.iso       = 1'b1;
                dec.fmt       = FMT_ISO;
            end
            MODE_ISO6:
            begin
                dec.iso = 1'b1;
                dec.fmt = FMT_ISO;
            end
            default:
            begin
                dec.fmt = FMT_BRF;
            end
        endcase
        return dec;
    endfunction

endpackage

### design/raster_to_braille_cells.sv
// ----------------------------------------------------------------------------
// raster_to_braille_cells: bilevel raster to braille text converter
// pixel stream in, utf-8 / iso / brf byte stream out, apb register port
// ----------------------------------------------------------------------------
// One dot_on pixel is accepted per clock in raster order, as long as the
// four-entry command queue has room; a pixel that completes a cell turns
// into one to four output bytes (utf-8 triple, iso byte or brf char,
// then newline), which leave one per clock through a registered output while
// byte_stall is low, so the byte side and the queue depth set the sustained
// pixel rate when many bytes are produced in a row. The cell store is a
// 1024-entry memory, one entry per column pair, with one read-modify-write
// per cell pair; after reset it is swept to zero, during which pix_stall stays
// high while register writes are still taken. Registers: width at 0x0, height
// at 0x4, format mode at 0x8; write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module raster_to_braille_cells (
    input  logic        clk,
    input  logic        rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel channel
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic        dot_on,
    // byte channel
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        image_done
);

    logic [rbc_pkg::WIDTH_W-1:0]  width_reg;
    logic [rbc_pkg::HEIGHT_W-1:0] height_reg;
    logic [rbc_pkg::MODE_W-1:0]   mode_reg;
    rbc_pkg::cfg_t                cfg;
    logic                         cfg_write;

    logic                         cmd_push;
    rbc_pkg::cmd_t                cmd_in;
    logic                         cmd_full;
    logic                         cmd_pop;
    logic                         cmd_valid;
    rbc_pkg::cmd_t                cmd_head;

    // register port: always ready, write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rbc_pkg::WIDTH_W'(rbc_pkg::MAX_COLUMNS);
            height_reg <= rbc_pkg::HEIGHT_W'(1);
            mode_reg   <= rbc_pkg::MODE_BRF6;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                rbc_pkg::REG_WIDTH:  width_reg  <= pwdata[rbc_pkg::WIDTH_W-1:0];
                rbc_pkg::REG_HEIGHT: height_reg <= pwdata[rbc_pkg::HEIGHT_W-1:0];
                rbc_pkg::REG_MODE:   mode_reg   <= pwdata[rbc_pkg::MODE_W-1:0];
                default:             ;
            endcase
        end
    end

    // read back, unmapped addresses read as zero
    always_comb
    begin
        case (paddr[3:2])
            rbc_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            rbc_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            rbc_pkg::REG_MODE:   prdata = 32'(mode_reg);
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.mode   = mode_reg;

    // front: position tracking, cell store merge, command issue
    rbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .dot_on    (dot_on),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in),
        .cmd_full  (cmd_full)
    );

    // queue decouples pixel intake from byte output bursts
    rbc_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head      (cmd_head)
    );

    // back: one byte per transaction on the output channel
    rbc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_head),
        .cmd_pop     (cmd_pop),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .image_done  (image_done)
    );

endmodule

### design/rbc_front.sv
// ----------------------------------------------------------------------------
// rbc_front: pixel intake and cell store
// tracks raster position, merges dots into the per-cell line store and
// issues one command per pixel that completes a cell or a band
// ----------------------------------------------------------------------------
module rbc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  rbc_pkg::cfg_t   cfg,
    input  logic            pix_valid,
    output logic            pix_stall,
    input  logic            dot_on,
    output logic            cmd_push,
    output rbc_pkg::cmd_t   cmd_data,
    input  logic            cmd_full
);

    typedef struct packed {
        logic                      odd;
        logic                      wr_back;
        logic [rbc_pkg::IDX_W-1:0] idx;
        logic [7:0]                mask;
        rbc_pkg::cell_fmt_t        fmt;
        logic                      has_cell;
        logic                      has_nl;
        logic                      img_done;
    } s1_t;

    logic [rbc_pkg::COL_W-1:0]    col_reg;
    logic [rbc_pkg::HEIGHT_W-1:0] row_reg;
    logic [1:0]                   band_reg;
    logic                         clearing_reg;
    logic [rbc_pkg::IDX_W-1:0]    clr_idx_reg;
    logic                         s1_valid_reg;
    s1_t                          s1_reg;
    s1_t                          s1_next;
    logic [7:0]                   acc_reg;
    logic [7:0]                   rdata_reg;
    logic [7:0]                   store_mem [rbc_pkg::STORE_CELLS];

    rbc_pkg::mode_dec_t          dec;
    logic [rbc_pkg::WIDTH_W-1:0] width_c;
    logic [rbc_pkg::HEIGHT_W-1:0] height_c;
    logic [2:0]                  band_h;
    logic                        row_end;
    logic                        image_end;
    logic                        band_end;
    logic [2:0]                  bit_base;
    logic [2:0]                  bit_pos;
    logic                        accept;
    logic [7:0]                  s1_cell;
    logic                        s1_needs_q;
    logic                        s1_retire;
    logic                        wr_en;
    logic [rbc_pkg::IDX_W-1:0]   wr_idx;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [rbc_pkg::IDX_W-1:0]   rd_idx;

    // position decode
    always_comb
    begin
        dec = rbc_pkg::decode_mode(cfg.mode);
        if (cfg.width == '0)
            width_c = rbc_pkg::WIDTH_W'(1);
        else if (cfg.width > rbc_pkg::WIDTH_W'(rbc_pkg::MAX_COLUMNS))
            width_c = rbc_pkg::WIDTH_W'(rbc_pkg::MAX_COLUMNS);
        else
            width_c = cfg.width;
        height_c  = (cfg.height == '0) ? rbc_pkg::HEIGHT_W'(1) : cfg.height;
        band_h    = dec.eight_dot ? 3'd4 : 3'd3;
        row_end   = ({1'b0, col_reg} + rbc_pkg::WIDTH_W'(1)) >= width_c;
        image_end = ({1'b0, row_reg} + 17'd1) >= {1'b0, height_c};
        band_end  = image_end || (({1'b0, band_reg} + 3'd1) >= band_h);

        case (band_reg)
            2'd0:    bit_base = 3'd0;
            2'd1:    bit_base = 3'd1;
            2'd2:    bit_base = 3'd2;
            default: bit_base = 3'd6;
        endcase
        if (col_reg[0])
            bit_pos = (bit_base == 3'd6) ? 3'd7 : bit_base + 3'd3;
        else
            bit_pos = bit_base;

        s1_next.odd      = col_reg[0];
        s1_next.wr_back  = col_reg[0] || row_end;
        s1_next.idx      = col_reg[rbc_pkg::COL_W-1:1];
        s1_next.mask     = 8'(dot_on) << bit_pos;
        s1_next.fmt      = dec.fmt;
        s1_next.has_cell = band_end && (col_reg[0] || row_end);
        s1_next.has_nl   = band_end && row_end && !dec.iso;
        s1_next.img_done = row_end && image_end;
    end

    // merge stage and handshake
    always_comb
    begin
        s1_cell    = (s1_reg.odd ? acc_reg : rdata_reg) | s1_reg.mask;
        s1_needs_q = s1_reg.has_cell || s1_reg.has_nl;
        s1_retire  = s1_valid_reg && (!s1_needs_q || !cmd_full);
        pix_stall  = clearing_reg || (s1_valid_reg && !s1_retire);
        accept     = pix_valid && !pix_stall;

        cmd_push          = s1_retire && s1_needs_q;
        cmd_data.dots     = s1_cell;
        cmd_data.fmt      = s1_reg.fmt;
        cmd_data.has_cell = s1_reg.has_cell;
        cmd_data.has_nl   = s1_reg.has_nl;
        cmd_data.img_done = s1_reg.img_done;

        wr_en   = clearing_reg || (s1_retire && s1_reg.wr_back);
        wr_idx  = clearing_reg ? clr_idx_reg : s1_reg.idx;
        wr_data = (clearing_reg || s1_reg.has_cell) ? 8'h00 : s1_cell;
        rd_en   = accept && !col_reg[0];
        rd_idx  = s1_next.idx;
    end

    // cell store with write-through on a same-cycle hit
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_idx] <= wr_data;
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
                rdata_reg <= wr_data;
            else
                rdata_reg <= store_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_retire && !s1_reg.odd)
            acc_reg <= s1_cell;
        if (accept)
            s1_reg <= s1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            band_reg     <= '0;
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == rbc_pkg::IDX_W'(rbc_pkg::STORE_CELLS - 1))
                    clearing_reg <= 1'b0;
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_retire)
                s1_valid_reg <= 1'b0;

            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    if (image_end)
                    begin
                        row_reg  <= '0;
                        band_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        band_reg <= band_end ? 2'd0 : band_reg + 2'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // nothing enters the merge stage while the store is being swept
    a_no_pixel_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("pixel in merge stage during store clearing");

    // the right column of a cell always follows its left column
    a_odd_after_even: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_reg[0] && s1_valid_reg) |-> !s1_reg.odd)
        else $error("two right-column pixels in a row");

endmodule

### design/rbc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rbc_cmd_fifo: command queue between pixel intake and byte serializer
// small register queue, push and pop in the same cycle allowed
// ----------------------------------------------------------------------------
module rbc_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rbc_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output rbc_pkg::cmd_t head
);

    rbc_pkg::cmd_t                 slot_reg [rbc_pkg::CMD_DEPTH];
    logic [rbc_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [rbc_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [rbc_pkg::CMD_CNT_W-1:0] count_reg;

    assign full      = (count_reg == rbc_pkg::CMD_CNT_W'(rbc_pkg::CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command queue overflow");

endmodule

### design/rbc_back.sv
// ----------------------------------------------------------------------------
// rbc_back: byte serializer
// expands each command into its utf-8, iso or brf bytes plus an optional newline and
// holds them in an output register
// ----------------------------------------------------------------------------
module rbc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  rbc_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          byte_valid,
    input  logic          byte_stall,
    output logic [7:0]    out_byte,
    output logic          last_of_run,
    output logic          image_done
);

    logic [1:0] step_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       done_reg;

    logic [1:0] cell_bytes;
    logic [2:0] total;
    logic       is_last;
    logic [7:0] next_byte;
    logic       load;

    always_comb
    begin
        if (!cmd.has_cell)
            cell_bytes = 2'd0;
        else if (cmd.fmt == rbc_pkg::FMT_UTF8)
            cell_bytes = 2'd3;
        else
            cell_bytes = 2'd1;
        total   = {1'b0, cell_bytes} + {2'b00, cmd.has_nl};
        is_last = ({1'b0, step_reg} + 3'd1) == total;

        if (step_reg < cell_bytes)
        begin
            case (cmd.fmt)
                rbc_pkg::FMT_UTF8:
                begin
                    if (step_reg == 2'd0)
                        next_byte = rbc_pkg::UTF8_LEAD;
                    else if (step_reg == 2'd1)
                        next_byte = rbc_pkg::UTF8_MID | {6'd0, cmd.dots[7:6]};
                    else
                        next_byte = rbc_pkg::UTF8_CONT | {2'd0, cmd.dots[5:0]};
                end
                rbc_pkg::FMT_ISO: next_byte = cmd.dots;
                default:          next_byte = rbc_pkg::BRF_TABLE[cmd.dots[5:0]];
            endcase
        end
        else
        begin
            next_byte = rbc_pkg::NEWLINE;
        end

        load    = cmd_valid && (!out_valid_reg || !byte_stall);
        cmd_pop = load && is_last;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= next_byte;
            last_reg     <= is_last;
            done_reg     <= is_last && cmd.img_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= is_last ? 2'd0 : step_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!byte_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign byte_valid  = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign image_done  = done_reg;

    // a command leaves the queue only with its final byte
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (out_valid_reg && last_reg))
        else $error("command popped without final byte");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("image end flag on a byte that is not last of run");

endmodule

### tb/sv/raster_to_braille_cells_tb.sv
// ----------------------------------------------------------------------------
// raster_to_braille_cells_tb: self-checking bench for the braille converter
// pixels go in through a bursty driver and bytes come out past a stalling
// sink. Every accepted pixel is run through a local model of the cell store
// and counters, and each byte is checked in order against it. Register
// settings change between phases only, once the byte stream has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module raster_to_braille_cells_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PIXELS = 72;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    // one byte of the output stream with its flags
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
    } braille_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    logic        dot_on = 1'b0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        image_done;

    // braille ascii glyph for each 6-dot pattern
    string brf_glyphs = " A1B'K2L@CIF/MSP\"E3H9O6R^DJG>NTQ,*5<-U8V.%[$+X!&;:4\\0Z7(_?W]#Y)=";

    // model copy of the registers
    logic [rbc_pkg::WIDTH_W-1:0]  cfg_width  = 12'd2048;
    logic [rbc_pkg::HEIGHT_W-1:0] cfg_height = 16'd1;
    logic [rbc_pkg::MODE_W-1:0]   cfg_mode   = rbc_pkg::MODE_BRF6;

    // model copy of the raster position and the cell store
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    int unsigned cur_band_row = 0;
    logic [7:0]  dot_cells [rbc_pkg::STORE_CELLS];

    braille_byte_t expected_bytes [$];
    logic          pixel_feed [$];

    int  pixels_queued = 0;
    int  pixels_taken = 0;
    int  errors = 0;
    int  cycle_count = 0;
    bit  pix_fired = 1'b0;

    // sender burst shaping and sink stall pattern
    int          burst_left = 0;
    int          gap_left = 0;
    logic [15:0] stall_word = '0;
    int          stall_tick = 0;

    raster_to_braille_cells i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .dot_on      (dot_on),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .image_done  (image_done)
    );

    always #5 clk = ~clk;

    // model of one pixel: place the dot, emit the finished cell and newline
    function automatic void predict_braille_bytes(input logic dot);
        int unsigned   span;
        int unsigned   rows;
        int unsigned   band_h;
        int unsigned   col;
        int unsigned   slot;
        int unsigned   pos;
        bit            eight_dot;
        bit            iso;
        bit            utf8;
        bit            row_end;
        bit            image_end;
        bit            band_end;
        logic [7:0]    cell_bits;
        braille_byte_t run [$];

        // zero and oversize widths clamp, zero height acts as one row
        span = cfg_width;
        if (span < 1)
            span = 1;
        if (span > rbc_pkg::MAX_COLUMNS)
            span = rbc_pkg::MAX_COLUMNS;
        rows = cfg_height;
        if (rows < 1)
            rows = 1;

        // codes five to seven fall through to brf 6-dot
        eight_dot = (cfg_mode == rbc_pkg::MODE_UTF8_8) || (cfg_mode == rbc_pkg::MODE_ISO8);
        iso       = (cfg_mode == rbc_pkg::MODE_ISO8) || (cfg_mode == rbc_pkg::MODE_ISO6);
        utf8      = (cfg_mode == rbc_pkg::MODE_UTF8_8) || (cfg_mode == rbc_pkg::MODE_UTF8_6);
        band_h    = eight_dot ? 4 : 3;

        // positions at or past a narrowed limit count as the last one
        col       = cur_col;
        slot      = (col >> 1) % rbc_pkg::STORE_CELLS;
        row_end   = (col + 1 >= span);
        image_end = (cur_row + 1 >= rows);
        band_end  = image_end || (cur_band_row + 1 >= band_h);

        // iso dot numbering: left column 0,1,2,6 and right column 3,4,5,7
        case (cur_band_row)
            0: pos = 0;
            1: pos = 1;
            2: pos = 2;
            default: pos = 6;
        endcase
        if ((col & 1) != 0)
            pos = (pos == 6) ? 7 : pos + 3;
        dot_cells[slot] = dot_cells[slot] | (8'(dot) << pos);

        // right column or an odd last column closes the cell on the band end
        if (band_end && (((col & 1) != 0) || row_end))
        begin
            cell_bits = dot_cells[slot];
            dot_cells[slot] = '0;
            if (utf8)
            begin
                run.push_back('{rbc_pkg::UTF8_LEAD, 1'b0, 1'b0});
                run.push_back('{rbc_pkg::UTF8_MID | (cell_bits >> 6), 1'b0, 1'b0});
                run.push_back('{rbc_pkg::UTF8_CONT | (cell_bits & 8'h3F), 1'b0, 1'b0});
            end
            else if (iso)
                run.push_back('{cell_bits, 1'b0, 1'b0});
            else
                run.push_back('{brf_glyphs[cell_bits[5:0]], 1'b0, 1'b0});
        end
        if (band_end && row_end && !iso)
            run.push_back('{rbc_pkg::NEWLINE, 1'b0, 1'b0});

        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
            if (row_end && image_end)
                run[run.size() - 1].done = 1'b1;
        end
        foreach (run[k])
            expected_bytes.push_back(run[k]);

        // advance the raster position, wrapping after the image
        if (row_end)
        begin
            cur_col = 0;
            if (image_end)
            begin
                cur_row = 0;
                cur_band_row = 0;
            end
            else
            begin
                cur_row = (cur_row + 1) & 16'hFFFF;
                cur_band_row = band_end ? 0 : ((cur_band_row + 1) & 3);
            end
        end
        else
            cur_col = col + 1;
    endfunction

    // acceptance, prediction and byte checking, all on the rising edge
    always @(posedge clk)
    begin : monitor
        braille_byte_t want;

        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                predict_braille_bytes(dot_on);
                pixels_taken++;
                pix_fired = 1'b1;
            end
            if (byte_valid && !byte_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: no transaction expected, actual %02h", out_byte);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
                        errors++;
                    end
                    if (image_done !== want.done)
                    begin
                        $error("image_done: expected %0d, actual %0d", want.done, image_done);
                        errors++;
                    end
                end
            end
        end

        // watchdog against a hung handshake
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("raster_to_braille_cells_tb: errors");
            $finish;
        end
    end

    // pixel driver and sink stall, both changing on the falling edge
    always @(negedge clk)
    begin
        // a stalled pixel stays put until it is taken
        if (!pix_valid || pix_fired)
        begin
            if (gap_left > 0)
            begin
                pix_valid <= 1'b0;
                gap_left--;
            end
            else if (pixel_feed.size() > 0)
            begin
                pix_valid <= 1'b1;
                dot_on <= pixel_feed.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                pix_valid <= 1'b0;
        end
        pix_fired = 1'b0;

        // sink pattern, drawn at random: none, light, half or heavy
        if (stall_tick % 64 == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_word = '0;
                1: stall_word = 16'($urandom & $urandom);
                2: stall_word = 16'($urandom);
                default: stall_word = 16'($urandom | $urandom);
            endcase
        end
        byte_stall <= stall_word[stall_tick % 16];
        stall_tick++;
    end

    // register write: setup cycle then access cycle
    task automatic write_register(input rbc_pkg::reg_index_t which, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (which)
            rbc_pkg::REG_WIDTH:  cfg_width = value[rbc_pkg::WIDTH_W-1:0];
            rbc_pkg::REG_HEIGHT: cfg_height = value[rbc_pkg::HEIGHT_W-1:0];
            default:             cfg_mode = value[rbc_pkg::MODE_W-1:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // block until every queued pixel is taken and every byte has arrived
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixels_taken != pixels_queued || expected_bytes.size() != 0);
    endtask

    task automatic queue_pixels(input int count, input fill_t fill);
        repeat (count)
        begin
            case (fill)
                FILL_ONES:  pixel_feed.push_back(1'b1);
                FILL_ZEROS: pixel_feed.push_back(1'b0);
                default:    pixel_feed.push_back(1'($urandom_range(0, 1)));
            endcase
            pixels_queued++;
        end
    endtask

    // one phase: drain, let pixels that make no byte settle, reprogram, feed
    task automatic run_phase(input int span, input int rows,
                             input logic [rbc_pkg::MODE_W-1:0] mode,
                             input int count, input fill_t fill, input bit pause_midway);
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        write_register(rbc_pkg::REG_WIDTH, span);
        write_register(rbc_pkg::REG_HEIGHT, rows);
        write_register(rbc_pkg::REG_MODE, 32'(mode));
        if (pause_midway)
        begin
            // sender holds off until the byte stream is empty, then resumes
            queue_pixels(count / 2, fill);
            wait_drained();
            queue_pixels(count - count / 2, fill);
        end
        else
            queue_pixels(count, fill);
    endtask

    initial
    begin : stimulus
        int span;
        int rows;
        int count;
        int random_pixels;
        bit first;

        foreach (dot_cells[k])
            dot_cells[k] = '0;

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed: full 8-dot cell, odd last column, clamps, short band
        run_phase(2, 4, rbc_pkg::MODE_UTF8_8, 8, FILL_ONES, 1'b0);
        run_phase(3, 1, rbc_pkg::MODE_UTF8_6, 3, FILL_RANDOM, 1'b0);
        run_phase(0, 0, 3'd7, 1, FILL_ONES, 1'b0);
        run_phase(1, 5, rbc_pkg::MODE_ISO8, 5, FILL_ONES, 1'b0);
        run_phase(2, 1, rbc_pkg::MODE_ISO6, 2, FILL_RANDOM, 1'b0);
        run_phase(2, 3, rbc_pkg::MODE_BRF6, 6, FILL_ZEROS, 1'b0);

        // random phases: mostly whole small images, some partial runs
        random_pixels = 0;
        first = 1'b1;
        while (random_pixels < RANDOM_PIXELS)
        begin
            span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            rows = $urandom_range(0, 6);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, 20);
            else
                count = (span == 0 ? 1 : span) * (rows == 0 ? 1 : rows);
            run_phase(span, rows, 3'($urandom_range(0, 7)), count, FILL_RANDOM, first);
            random_pixels += count;
            first = 1'b0;
        end

        // clamped oversize width, tallest image, then narrowing and shortening mid-image
        run_phase(4095, 1, rbc_pkg::MODE_ISO8, 24, FILL_RANDOM, 1'b0);
        run_phase(1, 65535, rbc_pkg::MODE_UTF8_8, 9, FILL_RANDOM, 1'b0);
        run_phase(2048, 3, rbc_pkg::MODE_UTF8_6, 5, FILL_RANDOM, 1'b0);
        run_phase(2, 2, rbc_pkg::MODE_ISO6, 12, FILL_RANDOM, 1'b0);
        run_phase(3, 4, rbc_pkg::MODE_BRF6, 12, FILL_RANDOM, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        if (errors == 0 && expected_bytes.size() == 0)
            $display("raster_to_braille_cells_tb: clean");
        else
            $display("raster_to_braille_cells_tb: errors");
        $finish;
    end

endmodule

### sim.f
design/rbc_pkg.sv
design/rbc_front.sv
design/rbc_cmd_fifo.sv
design/rbc_back.sv
design/raster_to_braille_cells.sv
tb/sv/raster_to_braille_cells_tb.sv
